// ===== design/ntcsh_pkg.sv =====
// Shared types, widths and constants of the thermistor temperature unit.
`default_nettype none

package ntcsh_pkg;

	localparam int SERIES_W = 20;
	localparam int COEF_W   = 40;
	localparam int CODE_W   = 16;
	localparam int WHOLE_W  = 10;
	localparam int HUND_W   = 8;
	localparam int ADC_BITS_DEF = 16;

	// log2 unit: mantissa held in [2^30, 2^31), 24 fraction bits out
	localparam int LOG_FRAC = 24;
	localparam int LOG_M_W  = 31;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Magnitude widths, sized for the largest converter width
	localparam int LMAG_W = 29;
	localparam int L2_W   = 34;
	localparam int L3_W   = 38;
	localparam int BT_W   = 46;
	localparam int CT_W   = 55;
	localparam int D_W    = 56;

	localparam int KELVIN_OFFSET_Q16 = 17901158;
	localparam int SAT_LIMIT_Q16     = 17901158 + 328 * 65536;

	// Quotient bits needed below the saturation limit
	localparam int Q_W       = $clog2(SAT_LIMIT_Q16);
	localparam int DIV_NUM_W = 64;
	// Denominators at or below this give a Kelvin value at or above the limit
	localparam logic [63:0] DIV_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'(SAT_LIMIT_Q16);

	localparam logic [SERIES_W-1:0] SERIES_RST = SERIES_W'(10000);
	localparam logic [COEF_W-1:0]   COEF_A_RST = 40'd284078485700;
	localparam logic [COEF_W-1:0]   COEF_B_RST = 40'd66946161695;
	localparam logic [COEF_W-1:0]   COEF_C_RST = 40'd56835503;

	typedef enum logic [1:0] {
		REG_SERIES,
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C
	} cfg_reg_t;

	typedef struct packed {
		logic vld;
		logic bad;
		logic sat;
	} side_t;

endpackage

`default_nettype wire

// ===== design/ntcsh_log2.sv =====
// Pipelined base-2 logarithm by repeated squaring, one result bit per stage.
`default_nettype none

module ntcsh_log2 import ntcsh_pkg::*; #(
	parameter int XW = 16,
	localparam int PW = $clog2(XW),
	localparam int YW = PW + LOG_FRAC
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	output logic [YW-1:0] y
);

	localparam int NW = XW + LOG_M_W - 1;

	logic [PW-1:0]      p_n;
	logic [NW-1:0]      norm;
	logic [LOG_M_W-1:0] m_s [LOG_FRAC+1];
	logic [PW-1:0]      p_s [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] f_s [LOG_FRAC+1];

	// find the top set bit and bring it to bit 30
	always_comb begin
		p_n = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				p_n = PW'(i);
			end
		end
		norm = (NW'(x) << (LOG_M_W - 1)) >> p_n;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= norm[LOG_M_W-1:0];
			p_s[0] <= p_n;
			f_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
		logic [2*LOG_M_W-1:0] sq;
		logic [LOG_M_W:0]     t;

		always_comb begin
			sq = (2*LOG_M_W)'(m_s[i-1]) * (2*LOG_M_W)'(m_s[i-1]);
			t  = sq[2*LOG_M_W-1:LOG_M_W-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i] <= t[LOG_M_W] ? t[LOG_M_W:1] : t[LOG_M_W-1:0];
				p_s[i] <= p_s[i-1];
				f_s[i] <= {f_s[i-1][LOG_FRAC-2:0], t[LOG_M_W]};
			end
		end
	end

	assign y = {p_s[LOG_FRAC], f_s[LOG_FRAC]};

endmodule

`default_nettype wire

// ===== design/ntcsh_div.sv =====
// Pipelined restoring divider of all-ones over the denominator, one quotient bit per stage.
`default_nettype none

module ntcsh_div import ntcsh_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [D_W-1:0] den,
	output logic [Q_W-1:0] quo
);

	// dividend bits above the quotient field, all ones
	localparam logic [D_W-1:0] REM0 = D_W'({(DIV_NUM_W - Q_W){1'b1}});

	logic [D_W-1:0] rem_s [Q_W];
	logic [D_W-1:0] den_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [D_W-1:0] rem_in;
		logic [D_W-1:0] den_in;
		logic [Q_W-1:0] quo_in;
		logic [D_W:0]   trial;

		if (i == 0) begin : g_first
			assign rem_in = REM0;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, 1'b1};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_in;
				if (trial >= {1'b0, den_in}) begin
					rem_s[i] <= D_W'(trial - {1'b0, den_in});
					quo_s[i] <= {quo_in[Q_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[D_W-1:0];
					quo_s[i] <= {quo_in[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

`default_nettype wire

// ===== design/ntc_steinhart_hart_temperature_unit.sv =====
// Top level: thermistor ADC code to Celsius by the Steinhart-Hart equation.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[15:0] adc_code
//  m_axis    out  m_axis_tvalid/tready       tdata[9:0] temp_whole, [17:10] temp_hundredths;
//                                            tuser fault
//  cfg       in   cfg_we                     cfg_index register, cfg_data value
//
//  One request enters per cycle while no result waits on m_axis_tready.
//  Most of the pipeline lies in the two 24-stage log2 squaring chains and the 26-stage
//  divider, one 31x31 squaring or one 56-bit subtract per stage.
//  arst_n clears the valid bits and loads the coefficient reset values.
//  The whole pipe holds while a result waits on m_axis_tready; nothing is lost.
`default_nettype none

module ntc_steinhart_hart_temperature_unit import ntcsh_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave side
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [15:0] adc_code
	// master side
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,   // [9:0] temp_whole, [17:10] temp_hundredths
	output logic              m_axis_tuser,   // [0] fault
	// configuration
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [COEF_W-1:0] cfg_data
);

	localparam int NUM_W  = SERIES_W + ADC_BITS;
	localparam int LGN_W  = $clog2(NUM_W) + LOG_FRAC;
	localparam int LGD_W  = $clog2(CODE_W) + LOG_FRAC;
	localparam int LG_LAT = LOG_FRAC + 1;
	localparam int TC_W   = Q_W + 1;
	localparam logic [CODE_W-1:0] FS = CODE_W'((1 << ADC_BITS) - 1);
	localparam logic [WHOLE_W-1:0] WHOLE_SAT = WHOLE_W'(327);
	localparam logic [HUND_W-1:0]  HUND_SAT  = HUND_W'(99);

	// configuration registers
	logic [SERIES_W-1:0] series_q;
	logic [COEF_W-1:0]   coef_a_q, coef_b_q, coef_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SERIES_RST;
			coef_a_q <= COEF_A_RST;
			coef_b_q <= COEF_B_RST;
			coef_c_q <= COEF_C_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SERIES: series_q <= cfg_data[SERIES_W-1:0];
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves whenever the output register can take a result
	logic en;
	logic out_vld_s11;

	assign en            = !out_vld_s11 || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: flag bad codes and a zero series resistor, form series * (FS - code)
	side_t             side_s1;
	logic [CODE_W-1:0] code_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [CODE_W-1:0] code_in;
	logic              bad_in;

	assign code_in = s_axis_tdata[CODE_W-1:0];
	assign bad_in  = (code_in == '0) || (code_in >= FS) || (series_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: s_axis_tvalid, bad: bad_in, sat: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1 <= code_in;
			num_s1  <= NUM_W'(series_q) * NUM_W'(ADC_BITS'(FS - code_in));
		end
	end

	// log2 of numerator and denominator of the resistance ratio
	logic [LGN_W-1:0] lgn;
	logic [LGD_W-1:0] lgd;

	ntcsh_log2 #(.XW(NUM_W)) u_log_num (
		.clk (clk),
		.en  (en),
		.x   (num_s1),
		.y   (lgn)
	);

	ntcsh_log2 #(.XW(CODE_W)) u_log_code (
		.clk (clk),
		.en  (en),
		.x   (code_s1),
		.y   (lgd)
	);

	side_t side_lg [LG_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LG_LAT; i++) begin
				side_lg[i] <= '0;
			end
		end else if (en) begin
			side_lg[0] <= side_s1;
			for (int i = 1; i < LG_LAT; i++) begin
				side_lg[i] <= side_lg[i-1];
			end
		end
	end

	// stages 2..9: lnR, the polynomial terms and the denominator
	side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	logic [LGN_W-1:0]     dmag_s2;
	logic                 neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [LMAG_W-1:0]    lmag_s3, lmag_s4;
	logic [L2_W-1:0]      l2_s4;
	logic [COEF_W-1+LMAG_W-20:0] bhi_s4;
	logic [20+LMAG_W-1:0] blo_s4;
	logic [L3_W-1:0]      l3_s5;
	logic [BT_W-1:0]      bt_s5, bt_s6, bt_s7;
	logic [COEF_W-20+L3_W-1:0] chi_s6;
	logic [20+L3_W-1:0]   clo_s6;
	logic [CT_W-1:0]      ct_s7;
	logic signed [D_W:0]  d_s8;
	logic [D_W-1:0]       den_s9;

	logic [LGN_W-1:0] lgd_x;
	logic [63:0]      lm_prod;
	logic [D_W-1:0]   term_sum;
	logic             d_sat;

	assign lgd_x    = LGN_W'(lgd);
	assign lm_prod  = 64'(dmag_s2) * 64'(LN2_Q32) + 64'h8000_0000;
	assign term_sum = D_W'(bt_s7) + D_W'(ct_s7);
	assign d_sat    = d_s8 <= $signed({1'b0, DIV_LIMIT[D_W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
			side_s9 <= '0;
		end else if (en) begin
			side_s2 <= side_lg[LG_LAT-1];
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			// mark non-positive or too small denominators
			side_s9 <= '{vld: side_s8.vld, bad: side_s8.bad, sat: d_sat};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// signed difference of the logs
			neg_s2  <= lgn < lgd_x;
			dmag_s2 <= (lgn < lgd_x) ? LGN_W'(lgd_x - lgn) : LGN_W'(lgn - lgd_x);
			// scale to natural log with rounding
			neg_s3  <= neg_s2;
			lmag_s3 <= lm_prod[32 +: LMAG_W];
			// lnR^2 and the split B product
			neg_s4  <= neg_s3;
			lmag_s4 <= lmag_s3;
			l2_s4   <= L2_W'((2*LMAG_W)'(lmag_s3) * (2*LMAG_W)'(lmag_s3) >> LOG_FRAC);
			bhi_s4  <= $bits(bhi_s4)'(coef_b_q[COEF_W-1:20]) * $bits(bhi_s4)'(lmag_s3);
			blo_s4  <= $bits(blo_s4)'(coef_b_q[19:0]) * $bits(blo_s4)'(lmag_s3);
			// lnR^3 and the recombined B term
			neg_s5  <= neg_s4;
			l3_s5   <= L3_W'((64'(l2_s4) * 64'(lmag_s4)) >> LOG_FRAC);
			bt_s5   <= BT_W'(((80'(bhi_s4) << 20) + 80'(blo_s4)) >> LOG_FRAC);
			// split C product
			neg_s6  <= neg_s5;
			bt_s6   <= bt_s5;
			chi_s6  <= $bits(chi_s6)'(coef_c_q[COEF_W-1:20]) * $bits(chi_s6)'(l3_s5);
			clo_s6  <= $bits(clo_s6)'(coef_c_q[19:0]) * $bits(clo_s6)'(l3_s5);
			// recombined C term
			neg_s7  <= neg_s6;
			bt_s7   <= bt_s6;
			ct_s7   <= CT_W'(((80'(chi_s6) << 20) + 80'(clo_s6)) >> LOG_FRAC);
			// denominator A +/- (B lnR + C lnR^3)
			d_s8    <= neg_s7 ? $signed((D_W+1)'(coef_a_q)) - $signed({1'b0, term_sum})
			                  : $signed((D_W+1)'(coef_a_q)) + $signed({1'b0, term_sum});
			den_s9  <= d_s8[D_W-1:0];
		end
	end

	// Kelvin = all-ones / denominator
	logic [Q_W-1:0] kel;

	ntcsh_div u_div (
		.clk (clk),
		.en  (en),
		.den (den_s9),
		.quo (kel)
	);

	side_t side_dv [Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Q_W; i++) begin
				side_dv[i] <= '0;
			end
		end else if (en) begin
			side_dv[0] <= side_s9;
			for (int i = 1; i < Q_W; i++) begin
				side_dv[i] <= side_dv[i-1];
			end
		end
	end

	// stage 10: Celsius magnitude and sign
	side_t           side_s10;
	logic [Q_W-1:0]  mag_s10;
	logic            tneg_s10;
	logic [TC_W-1:0] tc;

	assign tc = TC_W'(kel) - TC_W'(KELVIN_OFFSET_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s10 <= '0;
		end else if (en) begin
			side_s10 <= side_dv[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tneg_s10 <= tc[TC_W-1];
			mag_s10  <= tc[TC_W-1] ? Q_W'(-tc) : tc[Q_W-1:0];
		end
	end

	// stage 11: split into degrees and hundredths, apply faults; output register
	logic [WHOLE_W-1:0] whole_s11, whole_n;
	logic [HUND_W-1:0]  hund_s11, hund_n;
	logic               fault_s11;
	logic [22:0]        hprod;

	always_comb begin
		hprod   = 23'(mag_s10[15:0]) * 23'(100);
		whole_n = WHOLE_W'(mag_s10[Q_W-1:16]);
		hund_n  = HUND_W'(hprod[22:16]);
		if (tneg_s10) begin
			whole_n = -whole_n;
			hund_n  = -hund_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s11 <= 1'b0;
		end else if (en) begin
			out_vld_s11 <= side_s10.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s10.bad) begin
				whole_s11 <= '0;
				hund_s11  <= '0;
				fault_s11 <= 1'b1;
			end else if (side_s10.sat) begin
				whole_s11 <= WHOLE_SAT;
				hund_s11  <= HUND_SAT;
				fault_s11 <= 1'b1;
			end else begin
				whole_s11 <= whole_n;
				hund_s11  <= hund_n;
				fault_s11 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_s11;
	assign m_axis_tdata  = {6'b0, hund_s11, whole_s11};
	assign m_axis_tuser  = fault_s11;

endmodule

`default_nettype wire

// ===== design/ntcsh_chk.sv =====
// Port-level checker for the thermistor temperature unit, with its bind.
`default_nettype none

module ntcsh_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic signed [9:0] whole;
	logic signed [7:0] hund;

	assign whole = m_axis_tdata[9:0];
	assign hund  = m_axis_tdata[17:10];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> whole >= -273 && whole <= 327
		&& hund >= -99 && hund <= 99)
		else $error("temperature out of range without fault");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(whole < 0 && hund > 0) && !(whole > 0 && hund < 0))
		else $error("degrees and hundredths disagree in sign");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (whole == 0 && hund == 0)
		|| (whole == 327 && hund == 99))
		else $error("fault result has unexpected value");

endmodule

bind ntc_steinhart_hart_temperature_unit ntcsh_chk u_chk (.*);

`default_nettype wire

// ===== bench/ntcsh_checker.sv =====
// Checker for the thermistor temperature unit: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none

module ntcsh_checker import ntcsh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	input  wire logic              s_axis_tready,
	input  wire logic [15:0]       s_axis_tdata,
	input  wire logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	input  wire logic [23:0]       m_axis_tdata,
	input  wire logic              m_axis_tuser,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [COEF_W-1:0] cfg_data,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [HUND_W-1:0]  hund;
		logic               fault;
	} temp_t;

	logic [SERIES_W-1:0] series_q;
	logic [COEF_W-1:0]   ca_q, cb_q, cc_q;
	temp_t               temp_q[$];

	function automatic logic [63:0] mul_q24(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return p[87:24];
	endfunction

	function automatic logic [63:0] log2_q24(logic [63:0] x);
		int p;
		logic [63:0] m, frac;
		p = 0;
		frac = 0;
		while (p < 63 && (x >> (p + 1)) != 0)
			p++;
		m = (p <= 30) ? x << (30 - p) : x >> (p - 30);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'(1) << 31) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(p) << 24) | frac;
	endfunction

	function automatic temp_t predict_temp(logic [15:0] code);
		logic [63:0] fs, ln_n, ln_d, dmag, lmag, l2, l3, sum, k, mag;
		logic [127:0] wide;
		logic        neg;
		longint      den, tc;
		temp_t       t;
		fs = 64'hFFFF;
		t = '{whole: '0, hund: '0, fault: 1'b1};
		if (code == 0 || 64'(code) >= fs || series_q == 0)
			return t;
		ln_n = log2_q24(64'(series_q) * (fs - 64'(code)));
		ln_d = log2_q24(64'(code));
		neg = ln_n < ln_d;
		dmag = neg ? ln_d - ln_n : ln_n - ln_d;
		wide = dmag * 128'(LN2_Q32) + (128'(1) << 31);
		lmag = wide[95:32];
		l2 = mul_q24(lmag, lmag);
		l3 = mul_q24(l2, lmag);
		sum = mul_q24(64'(cb_q), lmag) + mul_q24(64'(cc_q), l3);
		den = neg ? longint'(ca_q) - longint'(sum) : longint'(ca_q) + longint'(sum);
		t = '{whole: WHOLE_W'(327), hund: HUND_W'(99), fault: 1'b1};
		if (den <= 0)
			return t;
		k = 64'hFFFF_FFFF_FFFF_FFFF / 64'(den);
		if (k >= 64'(SAT_LIMIT_Q16))
			return t;
		tc = longint'(k) - longint'(KELVIN_OFFSET_Q16);
		mag = (tc < 0) ? 64'(-tc) : 64'(tc);
		t.fault = 1'b0;
		t.whole = WHOLE_W'(mag >> 16);
		t.hund = HUND_W'(((mag & 64'hFFFF) * 100) >> 16);
		if (tc < 0) begin
			t.whole = -t.whole;
			t.hund = -t.hund;
		end
		return t;
	endfunction

	assign pending = temp_q.size();

	always @(posedge clk or negedge arst_n) begin
		temp_t got, want;
		if (!arst_n) begin
			series_q <= SERIES_RST;
			ca_q <= COEF_A_RST;
			cb_q <= COEF_B_RST;
			cc_q <= COEF_C_RST;
			mismatches <= 0;
			temp_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SERIES: series_q <= cfg_data[SERIES_W-1:0];
					REG_COEF_A: ca_q <= cfg_data;
					REG_COEF_B: cb_q <= cfg_data;
					REG_COEF_C: cc_q <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				temp_q.push_back(predict_temp(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{whole: m_axis_tdata[9:0], hund: m_axis_tdata[17:10],
					fault: m_axis_tuser};
				if (temp_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %p", got);
					mismatches <= mismatches + 1;
				end else begin
					want = temp_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("mismatch: expected %p got %p", want, got);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_ntc_steinhart_hart_temperature_unit.sv =====
// Testbench top: drives codes and register writes into the temperature unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_ntc_steinhart_hart_temperature_unit;
	import ntcsh_pkg::*;

	localparam int LATENCY = 62;
	localparam int STALL_LIMIT = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	int                mismatches, pending;
	int                idle_cycles = 0;
	bit                calm = 1'b0;   // no idling on either side
	bit                hold_sink = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ntc_steinhart_hart_temperature_unit dut (.*);

	ntcsh_checker checker_i (.*);

	// watchdog: count cycles in which no request moves on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("** ntc_steinhart_hart_temperature_unit: FAILED **");
			$finish;
		end
	end

	// receiver: random bursts of back-pressure, or a long hold-off when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 4);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// hold valid until accepted; idle a random burst beforehand now and then
	task automatic send_code(logic [15:0] code);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drain the pipe, then write one register while the block is idle
	task automatic write_reg(cfg_reg_t idx, logic [COEF_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// codes spread over the full range, with a bias toward the ends
	function automatic logic [15:0] rand_code();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 40));
			1: return 16'($urandom_range(65495, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++)
			send_code(rand_code());
	endtask

	initial begin
		logic [15:0] corner[];
		corner = '{16'd0, 16'd1, 16'd2, 16'd32767, 16'd32768, 16'd65533,
			16'd65534, 16'd65535, 16'hAAAA, 16'h5555, 16'd100, 16'd60000};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and the fault codes at reset settings
		foreach (corner[i])
			send_code(corner[i]);

		// fill the pipe while the receiver is held off for a long stretch
		hold_sink <= 1'b1;
		fork
			repeat (150) @(posedge clk);
			random_run(100);
		join_any
		hold_sink <= 1'b0;
		wait fork;
		random_run(300);

		// zero series resistor: every code faults
		write_reg(REG_SERIES, '0);
		send_code(16'd1000);
		send_code(16'd40000);
		// largest resistor with zero coefficients: denominator not positive
		write_reg(REG_SERIES, COEF_W'(20'hFFFFF));
		write_reg(REG_COEF_A, '0);
		write_reg(REG_COEF_B, '0);
		write_reg(REG_COEF_C, '0);
		random_run(60);
		// largest coefficients: very cold results
		write_reg(REG_COEF_A, '1);
		write_reg(REG_COEF_B, '1);
		write_reg(REG_COEF_C, '1);
		random_run(200);
		// smallest resistor, small A so many results saturate hot
		write_reg(REG_SERIES, COEF_W'(1));
		write_reg(REG_COEF_A, COEF_W'(40'd20000000000));
		write_reg(REG_COEF_B, COEF_W'(40'd66946161695));
		write_reg(REG_COEF_C, COEF_W'(40'd56835503));
		random_run(200);
		// random register settings around the stock curve
		repeat (3) begin
			write_reg(REG_SERIES, COEF_W'($urandom_range(1, 1000000)));
			write_reg(REG_COEF_A, {8'($urandom), 32'($urandom)});
			write_reg(REG_COEF_B, COEF_W'({$urandom} % 64'd200000000000));
			write_reg(REG_COEF_C, COEF_W'($urandom_range(0, 200000000)));
			random_run(120);
		end
		// back to the stock values, last stretch without idling
		write_reg(REG_SERIES, COEF_W'(SERIES_RST));
		write_reg(REG_COEF_A, COEF_A_RST);
		write_reg(REG_COEF_B, COEF_B_RST);
		write_reg(REG_COEF_C, COEF_C_RST);
		random_run(150);
		calm = 1'b1;
		random_run(150);
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("** ntc_steinhart_hart_temperature_unit: PASSED **");
		else
			$display("** ntc_steinhart_hart_temperature_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
